@@ hdl/psw_pkg.sv @@
// Shared package for the priority task scheduler with watchdog.
// Holds the default slot count, configuration reset values, status codes and
// the add/subtract function of the shared arithmetic unit. No dependencies.
package psw_pkg;

   localparam int TASK_SLOTS_DEFAULT = 8;

   localparam logic        WD_ENABLE_RESET  = 1'b1;
   localparam logic [31:0] WD_TIMEOUT_RESET = 32'd5000;
   localparam logic [15:0] WD_PERIOD_RESET  = 16'd1000;
   localparam logic [7:0]  NEW_PRI_RESET    = 8'd10;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NO_SLOT    = 2'd1,
      STATUS_BAD_TARGET = 2'd2
   } status_type;

   // 33-bit add or subtract; on subtract, bit 32 is the borrow (a < b).
   function automatic logic [32:0] alu_op(input logic [31:0] a, input logic [31:0] b,
                                          input logic sub);
      logic [32:0] res;
      if (sub) begin
         res = {1'b0, a} - {1'b0, b};
      end else begin
         res = {1'b0, a} + {1'b0, b};
      end
      return res;
   endfunction

endpackage

@@ hdl/priority_task_scheduler_watchdog.sv @@
// Top level of the priority task scheduler with watchdog: task table,
// sequencer and one shared 33-bit add/subtract unit.
// Depends on psw_pkg.
//
// One item is taken when start is high and busy is low; busy stays high while
// it is worked on, and its result shows on the rsp_ ports for one cycle with
// rsp_valid, in the cycle busy falls, and must be taken then. Arithmetic steps
// go through the single shared add/subtract unit, one operation per cycle.
// Yield, sleep, kill, feed and unused codes go through the execute state;
// create probes one slot per cycle from slot 1; schedule runs the throttle
// check when the watchdog is enabled, then, if the check runs, two unit
// operations per live slot, then one wake test per slot.
// Configuration writes are always ready and take effect at once, so they are
// to be issued only while the block is idle.
module priority_task_scheduler_watchdog #(
   parameter int TASK_SLOTS = psw_pkg::TASK_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_func,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_duration_ms,
   input  logic [2:0]  req_target_task,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [2:0]  rsp_task_id,
   output logic        rsp_switched,
   output logic        rsp_run_task,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IW = $clog2(TASK_SLOTS);
   localparam logic [IW-1:0] LAST_IDX = IW'(TASK_SLOTS - 1);

   localparam logic [1:0] CSR_WD_ENABLE  = 2'd0;
   localparam logic [1:0] CSR_WD_TIMEOUT = 2'd1;
   localparam logic [1:0] CSR_WD_PERIOD  = 2'd2;
   localparam logic [1:0] CSR_NEW_PRI    = 2'd3;

   localparam logic [2:0] FUNC_SCHEDULE = 3'd0;
   localparam logic [2:0] FUNC_YIELD    = 3'd1;
   localparam logic [2:0] FUNC_SLEEP    = 3'd2;
   localparam logic [2:0] FUNC_CREATE   = 3'd3;
   localparam logic [2:0] FUNC_KILL     = 3'd4;
   localparam logic [2:0] FUNC_FEED     = 3'd5;

   typedef enum logic [1:0] {
      SLOT_EMPTY    = 2'd0,
      SLOT_READY    = 2'd1,
      SLOT_RUNNING  = 2'd2,
      SLOT_SLEEPING = 2'd3
   } slot_state_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_THR_SUB,
      S_THR_CMP,
      S_WD_AGE,
      S_WD_CMP,
      S_PICK,
      S_SWITCH,
      S_CREATE
   } seq_state_type;

   seq_state_type  state_ff;
   slot_state_type slot_state_ff [TASK_SLOTS];
   logic [7:0]     slot_pri_ff   [TASK_SLOTS];
   logic [31:0]    slot_ly_ff    [TASK_SLOTS];
   logic [31:0]    slot_wake_ff  [TASK_SLOTS];
   logic [IW-1:0]  cur_ff;
   logic [31:0]    last_check_ff;

   logic        wd_enable_ff;
   logic [31:0] wd_timeout_ff;
   logic [15:0] wd_period_ff;
   logic [7:0]  new_pri_ff;

   logic [2:0]  func_ff;
   logic [31:0] now_ff;
   logic [31:0] dur_ff;
   logic [2:0]  target_ff;

   logic [IW-1:0] idx_ff;
   logic [31:0]   diff_ff;
   logic          found_ff;
   logic [IW-1:0] best_ff;
   logic [7:0]    best_pri_ff;

   logic       rsp_valid_ff;
   logic [1:0] rsp_status_ff;
   logic [2:0] rsp_task_id_ff;
   logic       rsp_switched_ff;
   logic       rsp_run_ff;

   logic [31:0] alu_a;
   logic [31:0] alu_b;
   logic        alu_sub;
   logic [32:0] alu_res;

   slot_state_type pick_state_in;
   logic           pick_take;
   logic [IW-1:0]  best_in;
   logic [IW-1:0]  tgt_idx;
   logic           tgt_bad;

   // Operand selection for the shared unit, at most one operation per sequencer state.
   always_comb begin
      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b1;
      case (state_ff)
         S_THR_SUB: begin
            alu_a = now_ff;
            alu_b = last_check_ff;
         end
         S_THR_CMP: begin
            alu_a = diff_ff;
            alu_b = {16'd0, wd_period_ff};
         end
         S_WD_AGE: begin
            alu_a = now_ff;
            alu_b = slot_ly_ff[idx_ff];
         end
         S_WD_CMP: begin
            alu_a = wd_timeout_ff;
            alu_b = diff_ff;
         end
         S_PICK: begin
            alu_a = now_ff;
            alu_b = slot_wake_ff[idx_ff];
         end
         S_EXEC: begin
            alu_a   = now_ff;
            alu_b   = dur_ff;
            alu_sub = 1'b0;
         end
         default: begin
            alu_sub = 1'b1;
         end
      endcase
   end

   assign alu_res = psw_pkg::alu_op(alu_a, alu_b, alu_sub);

   // A sleeping slot wakes when now is not below its wake time (no borrow).
   always_comb begin
      pick_state_in = slot_state_ff[idx_ff];
      if (pick_state_in == SLOT_SLEEPING && !alu_res[32]) begin
         pick_state_in = SLOT_READY;
      end
   end

   assign pick_take = (pick_state_in == SLOT_READY) &&
                      (!found_ff || slot_pri_ff[idx_ff] > best_pri_ff);
   assign best_in   = found_ff ? best_ff : '0;
   assign tgt_idx   = IW'(target_ff);
   assign tgt_bad   = (target_ff == 3'd0) || (32'(target_ff) >= TASK_SLOTS) ||
                      (slot_state_ff[tgt_idx] == SLOT_EMPTY);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         cur_ff        <= '0;
         last_check_ff <= '0;
         wd_enable_ff  <= psw_pkg::WD_ENABLE_RESET;
         wd_timeout_ff <= psw_pkg::WD_TIMEOUT_RESET;
         wd_period_ff  <= psw_pkg::WD_PERIOD_RESET;
         new_pri_ff    <= psw_pkg::NEW_PRI_RESET;
         for (int i = 0; i < TASK_SLOTS; i++) begin
            slot_state_ff[i] <= (i == 0) ? SLOT_READY : SLOT_EMPTY;
            slot_pri_ff[i]   <= '0;
            slot_ly_ff[i]    <= '0;
            slot_wake_ff[i]  <= '0;
         end
      end else begin
         rsp_valid_ff <= 1'b0;

         if (csr_valid) begin
            case (csr_index)
               CSR_WD_ENABLE:  wd_enable_ff  <= csr_wdata[0];
               CSR_WD_TIMEOUT: wd_timeout_ff <= csr_wdata;
               CSR_WD_PERIOD:  wd_period_ff  <= csr_wdata[15:0];
               CSR_NEW_PRI:    new_pri_ff    <= csr_wdata[7:0];
               default:        wd_enable_ff  <= wd_enable_ff;
            endcase
         end

         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  func_ff   <= req_func;
                  now_ff    <= req_now_ms;
                  dur_ff    <= req_duration_ms;
                  target_ff <= req_target_task;
                  idx_ff    <= '0;
                  found_ff  <= 1'b0;
                  if (req_func == FUNC_SCHEDULE) begin
                     state_ff <= wd_enable_ff ? S_THR_SUB : S_PICK;
                  end else if (req_func == FUNC_CREATE) begin
                     idx_ff   <= IW'(1);
                     state_ff <= S_CREATE;
                  end else begin
                     state_ff <= S_EXEC;
                  end
               end
            end

            S_EXEC: begin
               rsp_status_ff <= psw_pkg::STATUS_OK;
               case (func_ff)
                  FUNC_YIELD: begin
                     if (slot_state_ff[cur_ff] != SLOT_EMPTY) begin
                        slot_state_ff[cur_ff] <= SLOT_READY;
                        slot_ly_ff[cur_ff]    <= now_ff;
                     end
                  end
                  FUNC_SLEEP: begin
                     if (slot_state_ff[cur_ff] != SLOT_EMPTY) begin
                        slot_state_ff[cur_ff] <= SLOT_SLEEPING;
                        slot_wake_ff[cur_ff]  <= alu_res[31:0];
                        slot_ly_ff[cur_ff]    <= now_ff;
                     end
                  end
                  FUNC_KILL: begin
                     if (tgt_bad) begin
                        rsp_status_ff <= psw_pkg::STATUS_BAD_TARGET;
                     end else begin
                        slot_state_ff[tgt_idx] <= SLOT_EMPTY;
                     end
                  end
                  FUNC_FEED: begin
                     slot_ly_ff[cur_ff] <= now_ff;
                  end
                  default: begin
                     rsp_status_ff <= psw_pkg::STATUS_OK;
                  end
               endcase
               rsp_task_id_ff  <= 3'(cur_ff);
               rsp_switched_ff <= 1'b0;
               rsp_run_ff      <= 1'b0;
               rsp_valid_ff    <= 1'b1;
               state_ff        <= S_IDLE;
            end

            S_THR_SUB: begin
               diff_ff  <= alu_res[31:0];
               state_ff <= S_THR_CMP;
            end

            S_THR_CMP: begin
               // A borrow means the last check is more recent than the period.
               if (alu_res[32]) begin
                  state_ff <= S_PICK;
               end else begin
                  last_check_ff <= now_ff;
                  state_ff      <= S_WD_AGE;
               end
            end

            S_WD_AGE: begin
               if (slot_state_ff[idx_ff] == SLOT_EMPTY ||
                   slot_state_ff[idx_ff] == SLOT_SLEEPING) begin
                  if (idx_ff == LAST_IDX) begin
                     idx_ff   <= '0;
                     state_ff <= S_PICK;
                  end else begin
                     idx_ff <= idx_ff + IW'(1);
                  end
               end else begin
                  diff_ff  <= alu_res[31:0];
                  state_ff <= S_WD_CMP;
               end
            end

            S_WD_CMP: begin
               // A borrow here means the age exceeds the timeout.
               if (alu_res[32]) begin
                  if (slot_state_ff[idx_ff] == SLOT_RUNNING) begin
                     slot_state_ff[idx_ff] <= SLOT_READY;
                  end
                  slot_ly_ff[idx_ff] <= now_ff;
               end
               if (idx_ff == LAST_IDX) begin
                  idx_ff   <= '0;
                  state_ff <= S_PICK;
               end else begin
                  idx_ff   <= idx_ff + IW'(1);
                  state_ff <= S_WD_AGE;
               end
            end

            S_PICK: begin
               slot_state_ff[idx_ff] <= pick_state_in;
               if (pick_take) begin
                  found_ff    <= 1'b1;
                  best_ff     <= idx_ff;
                  best_pri_ff <= slot_pri_ff[idx_ff];
               end
               if (idx_ff == LAST_IDX) begin
                  state_ff <= S_SWITCH;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end

            S_SWITCH: begin
               if (best_in != cur_ff) begin
                  if (slot_state_ff[cur_ff] == SLOT_RUNNING) begin
                     slot_state_ff[cur_ff] <= SLOT_READY;
                  end
                  slot_state_ff[best_in] <= SLOT_RUNNING;
                  cur_ff          <= best_in;
                  rsp_switched_ff <= 1'b1;
                  rsp_run_ff      <= (best_in != '0);
               end else begin
                  rsp_switched_ff <= 1'b0;
                  rsp_run_ff      <= (cur_ff != '0) && (slot_state_ff[cur_ff] == SLOT_RUNNING);
               end
               rsp_status_ff  <= psw_pkg::STATUS_OK;
               rsp_task_id_ff <= 3'(best_in);
               rsp_valid_ff   <= 1'b1;
               state_ff       <= S_IDLE;
            end

            S_CREATE: begin
               if (slot_state_ff[idx_ff] == SLOT_EMPTY) begin
                  slot_state_ff[idx_ff] <= SLOT_READY;
                  slot_pri_ff[idx_ff]   <= new_pri_ff;
                  slot_ly_ff[idx_ff]    <= now_ff;
                  slot_wake_ff[idx_ff]  <= '0;
                  rsp_status_ff         <= psw_pkg::STATUS_OK;
                  rsp_task_id_ff        <= 3'(idx_ff);
                  rsp_switched_ff       <= 1'b0;
                  rsp_run_ff            <= 1'b0;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= S_IDLE;
               end else if (idx_ff == LAST_IDX) begin
                  rsp_status_ff   <= psw_pkg::STATUS_NO_SLOT;
                  rsp_task_id_ff  <= 3'd0;
                  rsp_switched_ff <= 1'b0;
                  rsp_run_ff      <= 1'b0;
                  rsp_valid_ff    <= 1'b1;
                  state_ff        <= S_IDLE;
               end else begin
                  idx_ff <= idx_ff + IW'(1);
               end
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign busy         = (state_ff != S_IDLE);
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_task_id  = rsp_task_id_ff;
   assign rsp_switched = rsp_switched_ff;
   assign rsp_run_task = rsp_run_ff;

endmodule

@@ hdl/psw_checker.sv @@
// Port-level assertions for the priority task scheduler with watchdog,
// bound to the top level. Depends on psw_pkg and the top level's ports.
module psw_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [1:0] rsp_status,
   input logic [2:0] rsp_task_id,
   input logic       rsp_switched,
   input logic       rsp_run_task
);

   // An accepted item always makes the block busy in the cycle after it is taken.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("block not busy after an accepted item");

   // A result is shown in the cycle the block goes idle again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of an item");

   // Failed creates and kills never report a switch or a running task.
   a_err_flags: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != psw_pkg::STATUS_OK) |-> (!rsp_switched && !rsp_run_task))
      else $error("error status with switch or run flag set");

   // A create with no free slot reports slot zero.
   a_noslot_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == psw_pkg::STATUS_NO_SLOT) |-> (rsp_task_id == 3'd0))
      else $error("no-slot status with nonzero task id");

endmodule

bind priority_task_scheduler_watchdog psw_checker u_psw_checker (.*);
